FILE: rtl/core/rfkb_pkg.sv
package rfkb_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE        = 3'd0,
        CFG_ORIGIN_X    = 3'd1,
        CFG_ORIGIN_Y    = 3'd2,
        CFG_RECT_WIDTH  = 3'd3,
        CFG_RECT_HEIGHT = 3'd4,
        CFG_FILL_COLOR  = 3'd5
    } t_cfg_idx;

    // Drawing modes
    localparam logic MODE_FILL = 1'b0;
    localparam logic MODE_KEYED_COPY = 1'b1;

    // Field widths
    localparam int PIX_W   = 16;
    localparam int ADDR_W  = 18;
    localparam int BE_W    = 2;
    localparam int DIM_W   = 11;
    localparam int CNT_W   = 10;
    localparam int CFG_DATA_W = 16;

    // Transparent byte value in keyed-copy mode
    localparam logic [7:0] KEY_BYTE = 8'hFF;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // One classified pixel on its way to the back
    typedef struct packed {
        logic [CNT_W-1:0] ty;
        logic [CNT_W-1:0] tx;
        logic [PIX_W-1:0] data;
        logic [BE_W-1:0]  be;
        logic             done;
    } t_item;

endpackage

FILE: rtl/core/rfkb_ifs.sv
interface rfkb_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_data;

    modport source (output valid, output pixel_data, input ready);
    modport sink (input valid, input pixel_data, output ready);
endinterface

interface rfkb_res_if;
    logic        valid;
    logic        ready;
    logic [17:0] byte_address;
    logic [15:0] write_data;
    logic [1:0]  byte_enable;
    logic        rect_done;

    modport source (output valid, output byte_address, output write_data,
                    output byte_enable, output rect_done, input ready);
    modport sink (input valid, input byte_address, input write_data,
                  input byte_enable, input rect_done, output ready);
endinterface

interface rfkb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/rfkb_front.sv
module rfkb_front #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rfkb_pix_if.sink             i_pix,
    rfkb_cfg_if.sink             i_cfg,
    input  logic                 i_q_full,
    output logic                 o_push,
    output rfkb_pkg::t_item      o_item
);

    localparam logic signed [rfkb_pkg::DIM_W:0] SW = (rfkb_pkg::DIM_W + 1)'(SCREEN_WIDTH);
    localparam logic signed [rfkb_pkg::DIM_W:0] SH = (rfkb_pkg::DIM_W + 1)'(SCREEN_HEIGHT);

    logic                          r_mode;
    logic [rfkb_pkg::DIM_W-1:0]    r_origin_x;
    logic [rfkb_pkg::DIM_W-1:0]    r_origin_y;
    logic [rfkb_pkg::DIM_W-1:0]    r_rect_width;
    logic [rfkb_pkg::DIM_W-1:0]    r_rect_height;
    logic [rfkb_pkg::PIX_W-1:0]    r_fill_color;
    logic [rfkb_pkg::CNT_W-1:0]    r_col;
    logic [rfkb_pkg::CNT_W-1:0]    r_row;
    logic [rfkb_pkg::CNT_W-1:0]    n_col;
    logic [rfkb_pkg::CNT_W-1:0]    n_row;

    logic signed [rfkb_pkg::DIM_W:0] tx_s;
    logic signed [rfkb_pkg::DIM_W:0] ty_s;
    logic                          visible;
    logic                          last_col;
    logic                          last_row;
    logic [rfkb_pkg::PIX_W-1:0]    data;
    logic [rfkb_pkg::BE_W-1:0]     be;
    logic [rfkb_pkg::DIM_W-1:0]    width_m1;
    logic [rfkb_pkg::DIM_W-1:0]    height_m1;

    // Take configuration writes at any time
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= rfkb_pkg::MODE_FILL;
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_rect_width  <= rfkb_pkg::DIM_W'(1);
            r_rect_height <= rfkb_pkg::DIM_W'(1);
            r_fill_color  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                rfkb_pkg::CFG_MODE:        r_mode        <= i_cfg.data[0];
                rfkb_pkg::CFG_ORIGIN_X:    r_origin_x    <= i_cfg.data[rfkb_pkg::DIM_W-1:0];
                rfkb_pkg::CFG_ORIGIN_Y:    r_origin_y    <= i_cfg.data[rfkb_pkg::DIM_W-1:0];
                rfkb_pkg::CFG_RECT_WIDTH:  r_rect_width  <= i_cfg.data[rfkb_pkg::DIM_W-1:0];
                rfkb_pkg::CFG_RECT_HEIGHT: r_rect_height <= i_cfg.data[rfkb_pkg::DIM_W-1:0];
                rfkb_pkg::CFG_FILL_COLOR:  r_fill_color  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Accept a pixel whenever the queue has room
    assign i_pix.ready = !i_q_full;
    assign o_push      = i_pix.valid && !i_q_full;

    // Screen position, clipping and rectangle edges
    always_comb begin
        tx_s = $signed({r_origin_x[rfkb_pkg::DIM_W-1], r_origin_x})
             + $signed({2'b00, r_col});
        ty_s = $signed({r_origin_y[rfkb_pkg::DIM_W-1], r_origin_y})
             + $signed({2'b00, r_row});
        visible = !tx_s[rfkb_pkg::DIM_W] && !ty_s[rfkb_pkg::DIM_W]
               && (tx_s < SW) && (ty_s < SH);
        width_m1  = r_rect_width - rfkb_pkg::DIM_W'(1);
        height_m1 = r_rect_height - rfkb_pkg::DIM_W'(1);
        last_col  = {1'b0, r_col} == width_m1;
        last_row  = {1'b0, r_row} == height_m1;
        data = (r_mode == rfkb_pkg::MODE_KEYED_COPY) ? i_pix.pixel_data : r_fill_color;
        be = '0;
        if (visible) begin
            if (r_mode == rfkb_pkg::MODE_KEYED_COPY) begin
                be[1] = data[15:8] != rfkb_pkg::KEY_BYTE;
                be[0] = data[7:0] != rfkb_pkg::KEY_BYTE;
            end else begin
                be = '1;
            end
        end
        o_item.tx   = visible ? tx_s[rfkb_pkg::CNT_W-1:0] : '0;
        o_item.ty   = visible ? ty_s[rfkb_pkg::CNT_W-1:0] : '0;
        o_item.data = data;
        o_item.be   = be;
        o_item.done = last_col && last_row;
    end

    // Advance the raster walk
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (o_push) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + rfkb_pkg::CNT_W'(1);
            end else begin
                n_col = r_col + rfkb_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    a_done_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_item.done) |=> (r_col == '0 && r_row == '0))
        else $error("walk did not rewind after last pixel");

    a_clip_no_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !visible) |-> (o_item.be == '0 && o_item.tx == '0 && o_item.ty == '0))
        else $error("clipped pixel carries enables or position");

endmodule

FILE: rtl/core/rfkb_queue.sv
module rfkb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rfkb_pkg::t_item   i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output rfkb_pkg::t_item   o_item
);

    rfkb_pkg::t_item                  r_mem [rfkb_pkg::QUEUE_DEPTH];
    logic [rfkb_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [rfkb_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [rfkb_pkg::QCNT_W-1:0]      r_count;

    assign o_full  = r_count == rfkb_pkg::QCNT_W'(rfkb_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];

    // Store the entering transaction
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Move the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + rfkb_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + rfkb_pkg::QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + rfkb_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - rfkb_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

endmodule

FILE: rtl/core/rfkb_back.sv
module rfkb_back #(
    parameter int SCREEN_WIDTH = 320
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  rfkb_pkg::t_item   i_item,
    output logic              o_pop,
    rfkb_res_if.source        o_res
);

    localparam int LIN_W = 2 * rfkb_pkg::DIM_W;

    logic                          r_valid;
    logic [rfkb_pkg::ADDR_W-1:0]   r_addr;
    logic [rfkb_pkg::PIX_W-1:0]    r_data;
    logic [rfkb_pkg::BE_W-1:0]     r_be;
    logic                          r_done;
    logic [LIN_W-1:0]              lin;
    logic [rfkb_pkg::ADDR_W-1:0]   addr;

    // Load the output register when it is empty or being drained
    assign o_pop = i_q_valid && (!r_valid || o_res.ready);

    // Linear pixel index times two bytes, kept to the address width
    always_comb begin
        lin  = LIN_W'(i_item.ty) * LIN_W'(SCREEN_WIDTH) + LIN_W'(i_item.tx);
        addr = {lin[rfkb_pkg::ADDR_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_addr <= addr;
            r_data <= i_item.data;
            r_be   <= i_item.be;
            r_done <= i_item.done;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.byte_address = r_addr;
    assign o_res.write_data   = r_data;
    assign o_res.byte_enable  = r_be;
    assign o_res.rect_done    = r_done;

    a_stall_blocks_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_res.ready) |-> !o_pop)
        else $error("output overwritten while stalled");

endmodule

FILE: rtl/core/rect_fill_and_keyed_blit.sv
// An accepted pixel is written into the queue, then moves into the output
// register that drives the result port when that register is empty or drained.
// Throughput: one pixel per cycle through front, two-entry queue and back (one
// constant multiply) unless o_res stalls; a full queue takes no pixel even as it pops.
// Reset (i_rst_n low at a clock edge) empties the queue and output register,
// rewinds the raster walk and restores the register defaults.
module rect_fill_and_keyed_blit #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rfkb_pix_if.sink      i_pix,
    rfkb_cfg_if.sink      i_cfg,
    rfkb_res_if.source    o_res
);

    logic              q_full;
    logic              push;
    logic              pop;
    logic              q_valid;
    rfkb_pkg::t_item   push_item;
    rfkb_pkg::t_item   head_item;

    rfkb_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (push_item)
    );

    rfkb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    rfkb_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (head_item),
        .o_pop     (pop),
        .o_res     (o_res)
    );

endmodule
